// File: hdl/apm_pkg.sv
package apm_pkg;

    localparam int NCH    = 8;
    localparam int CH_W   = 3;
    localparam int SMP_W  = 24;
    localparam int MAG_W  = 24;
    localparam int MS_W   = 48;
    localparam int COEF_W = 25;
    localparam int ACT_W  = 4;
    localparam int ACC_W  = 72;
    localparam int CNT_W  = 5;
    localparam int IDX_W  = 1;

    localparam logic [COEF_W-1:0] COEF_ONE    = COEF_W'(1) << 24;
    localparam logic [COEF_W-1:0] COEF_RESET  = COEF_W'(1165);
    localparam logic [ACT_W-1:0]  ACT_RESET   = ACT_W'(2);
    localparam logic [ACT_W-1:0]  ACT_MAX     = ACT_W'(NCH);
    localparam logic [ACC_W-1:0]  ROUND_HALF  = ACC_W'(1) << 23;
    localparam logic [MS_W-1:0]   SQRT_BIT0   = MS_W'(1) << 46;
    localparam logic [CNT_W-1:0]  MUL_STEPS   = CNT_W'(COEF_W - 1);
    localparam logic [CNT_W-1:0]  SQRT_STEPS  = CNT_W'(23);

    localparam logic REQ_SAMPLE  = 1'b0;
    localparam logic REQ_CONSUME = 1'b1;
    localparam logic REP_BLOCK   = 1'b0;
    localparam logic REP_CONSUME = 1'b1;

    localparam logic [IDX_W-1:0] REG_COEF   = 1'b0;
    localparam logic [IDX_W-1:0] REG_ACTIVE = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [CH_W-1:0]  channel;
        logic [MAG_W-1:0] peak;
        logic [MAG_W-1:0] rms;
        logic [MAG_W-1:0] psr;
        logic             clip;
        logic [MAG_W-1:0] lpeak;
        logic [MAG_W-1:0] lrms;
    } apm_report_t;

endpackage

// File: hdl/apm_alu.sv
module apm_alu
    import apm_pkg::*;
(
    input  logic [ACC_W-1:0] a,
    input  logic [ACC_W-1:0] b,
    input  logic             sub,
    output logic [ACC_W-1:0] sum,
    output logic             ge
);

    logic [ACC_W:0] full;

    assign full = {1'b0, a} + {1'b0, b ^ {ACC_W{sub}}} + (ACC_W+1)'(sub);
    assign sum  = full[ACC_W-1:0];
    assign ge   = full[ACC_W];

endmodule

// File: hdl/apm_core.sv
module apm_core
    import apm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              req_type,
    input  logic [SMP_W-1:0]  sample_value,
    input  logic [CH_W-1:0]   channel_index,
    input  logic              block_end,
    input  logic [COEF_W-1:0] coef,
    input  logic [ACT_W-1:0]  n_active,
    output logic              rep_valid,
    input  logic              rep_take,
    output apm_report_t       rep
);

    typedef enum logic [3:0] {
        S_IDLE, S_MAG, S_SQR, S_DIFF, S_DIFFN, S_MUL, S_RND, S_UPD,
        S_SQRT, S_FIN, S_CONS, S_SCAN, S_DONE
    } state_t;

    state_t state_reg;

    logic [SMP_W-1:0]  smp_reg;
    logic [CH_W-1:0]   ch_reg;
    logic              be_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic [MS_W-1:0]   sq_reg;
    logic [MS_W-1:0]   msv_reg;
    logic [MS_W-1:0]   d_reg;
    logic              neg_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [MS_W-1:0]   v_reg;
    logic [MS_W-1:0]   res_reg;
    logic [MS_W-1:0]   bit_reg;
    logic [CH_W-1:0]   idx_reg;
    logic              clip_reg;
    logic [MAG_W-1:0]  held_reg;
    apm_report_t       rep_reg;

    logic [MS_W-1:0]   ms_reg [NCH];
    logic [MAG_W-1:0]  rp_reg [NCH];
    logic [MAG_W-1:0]  sp_reg [NCH];
    logic [MAG_W-1:0]  sr_reg [NCH];

    logic [ACC_W-1:0]  alu_a;
    logic [ACC_W-1:0]  alu_b;
    logic              alu_sub;
    logic [ACC_W-1:0]  alu_sum;
    logic              alu_ge;

    logic [MAG_W-1:0]  abs_val;
    logic [MAG_W-1:0]  cur_peak;
    logic [MAG_W-1:0]  held_next;
    logic [MS_W-1:0]   mag_sq;

    apm_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .sum (alu_sum),
        .ge  (alu_ge)
    );

    assign abs_val   = smp_reg[SMP_W-1] ? (~smp_reg + MAG_W'(1)) : smp_reg;
    assign cur_peak  = rp_reg[ch_reg];
    assign held_next = (cur_peak > held_reg) ? cur_peak : held_reg;
    assign mag_sq    = mag_reg * mag_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign rep_valid = (state_reg == S_DONE);
    assign rep       = rep_reg;

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            S_DIFF: begin
                alu_a   = ACC_W'(sq_reg);
                alu_b   = ACC_W'(msv_reg);
                alu_sub = 1'b1;
            end
            S_DIFFN: begin
                alu_a   = ACC_W'(msv_reg);
                alu_b   = ACC_W'(sq_reg);
                alu_sub = 1'b1;
            end
            S_MUL: begin
                alu_a = acc_reg << 1;
                alu_b = coef[cnt_reg] ? ACC_W'(d_reg) : '0;
            end
            S_RND: begin
                alu_a = acc_reg;
                alu_b = ROUND_HALF;
            end
            S_UPD: begin
                alu_a   = ACC_W'(msv_reg);
                alu_b   = ACC_W'(acc_reg[ACC_W-1:24]);
                alu_sub = neg_reg;
            end
            S_SQRT: begin
                alu_a   = ACC_W'(v_reg);
                alu_b   = ACC_W'(res_reg | bit_reg);
                alu_sub = 1'b1;
            end
            default: begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            clip_reg  <= 1'b0;
            held_reg  <= '0;
            for (int i = 0; i < NCH; i++) begin
                ms_reg[i] <= '0;
                rp_reg[i] <= '0;
                sp_reg[i] <= '0;
                sr_reg[i] <= '0;
            end
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (in_valid) begin
                        smp_reg <= sample_value;
                        ch_reg  <= channel_index;
                        be_reg  <= block_end;
                        if (req_type == REQ_CONSUME) begin
                            state_reg <= S_CONS;
                        end else begin
                            state_reg <= S_MAG;
                        end
                    end
                end
                S_MAG: begin
                    mag_reg <= abs_val;
                    if (abs_val > rp_reg[ch_reg]) begin
                        rp_reg[ch_reg] <= abs_val;
                    end
                    state_reg <= S_SQR;
                end
                S_SQR: begin
                    sq_reg    <= mag_sq;
                    msv_reg   <= ms_reg[ch_reg];
                    state_reg <= S_DIFF;
                end
                S_DIFF: begin
                    acc_reg <= '0;
                    cnt_reg <= MUL_STEPS;
                    if (alu_ge) begin
                        d_reg     <= alu_sum[MS_W-1:0];
                        neg_reg   <= 1'b0;
                        state_reg <= S_MUL;
                    end else begin
                        state_reg <= S_DIFFN;
                    end
                end
                S_DIFFN: begin
                    d_reg     <= alu_sum[MS_W-1:0];
                    neg_reg   <= 1'b1;
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    acc_reg <= alu_sum;
                    if (cnt_reg == '0) begin
                        state_reg <= S_RND;
                    end else begin
                        cnt_reg <= cnt_reg - CNT_W'(1);
                    end
                end
                S_RND: begin
                    acc_reg   <= alu_sum;
                    state_reg <= S_UPD;
                end
                S_UPD: begin
                    ms_reg[ch_reg] <= alu_sum[MS_W-1:0];
                    v_reg          <= alu_sum[MS_W-1:0];
                    res_reg        <= '0;
                    bit_reg        <= SQRT_BIT0;
                    cnt_reg        <= SQRT_STEPS;
                    if (be_reg) begin
                        state_reg <= S_SQRT;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_SQRT: begin
                    if (alu_ge) begin
                        v_reg   <= alu_sum[MS_W-1:0];
                        res_reg <= (res_reg >> 1) | bit_reg;
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (cnt_reg == '0) begin
                        state_reg <= S_FIN;
                    end else begin
                        cnt_reg <= cnt_reg - CNT_W'(1);
                    end
                end
                S_FIN: begin
                    sp_reg[ch_reg]  <= cur_peak;
                    sr_reg[ch_reg]  <= res_reg[MAG_W-1:0];
                    rp_reg[ch_reg]  <= '0;
                    held_reg        <= held_next;
                    clip_reg        <= clip_reg | cur_peak[MAG_W-1];
                    rep_reg.kind    <= REP_BLOCK;
                    rep_reg.channel <= ch_reg;
                    rep_reg.peak    <= cur_peak;
                    rep_reg.rms     <= res_reg[MAG_W-1:0];
                    rep_reg.psr     <= held_next;
                    rep_reg.lpeak   <= '0;
                    rep_reg.lrms    <= '0;
                    idx_reg         <= '0;
                    state_reg       <= S_SCAN;
                end
                S_CONS: begin
                    held_reg        <= '0;
                    rep_reg.kind    <= REP_CONSUME;
                    rep_reg.channel <= '0;
                    rep_reg.peak    <= '0;
                    rep_reg.rms     <= '0;
                    rep_reg.psr     <= held_reg;
                    rep_reg.lpeak   <= '0;
                    rep_reg.lrms    <= '0;
                    idx_reg         <= '0;
                    state_reg       <= S_SCAN;
                end
                S_SCAN: begin
                    if ({1'b0, idx_reg} < n_active) begin
                        if (sp_reg[idx_reg] > rep_reg.lpeak) begin
                            rep_reg.lpeak <= sp_reg[idx_reg];
                        end
                        if (sr_reg[idx_reg] > rep_reg.lrms) begin
                            rep_reg.lrms <= sr_reg[idx_reg];
                        end
                    end
                    if (idx_reg == CH_W'(NCH - 1)) begin
                        rep_reg.clip <= clip_reg;
                        state_reg    <= S_DONE;
                    end else begin
                        idx_reg <= idx_reg + CH_W'(1);
                    end
                end
                S_DONE: begin
                    if (rep_take) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hdl/audio_peak_rms_meter_unit.sv
// Multichannel linear peak and RMS level meter.
// The input channel (s_ prefix) takes transactions that are either an audio
// sample tagged with its channel or a request to consume the peak-since-read
// value. The result channel (m_ prefix) delivers one report per block end and
// one per consume request; samples without a block end produce no report.
// A single shared adder/subtractor performs the mean-square update
// (25 shift-add multiply steps plus rounding) and the 24-step integer square
// root, and the loudest stored values of the active channels are found by a scan.
// The input is not ready while an item is being processed.
// Reports go to an output register, so a new item can be accepted while a
// report waits for m_ready; if the receiver stalls, the core holds its next
// report until the output register is free.
// Configuration is written through cfg_wr_en, cfg_index and cfg_data; the
// user must write it only while the block is idle, as the block itself does
// not enforce this. Synchronous reset clears all channel state, the clip flag
// and the held peak, and restores the register defaults.
module audio_peak_rms_meter_unit
    import apm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [COEF_W-1:0] cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_req_type,
    input  logic [SMP_W-1:0]  s_sample_value,
    input  logic [CH_W-1:0]   s_channel_index,
    input  logic              s_block_end,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_report_kind,
    output logic [CH_W-1:0]   m_report_channel,
    output logic [MAG_W-1:0]  m_channel_peak,
    output logic [MAG_W-1:0]  m_channel_rms,
    output logic [MAG_W-1:0]  m_peak_since_read_value,
    output logic              m_clip_seen,
    output logic [MAG_W-1:0]  m_loudest_peak,
    output logic [MAG_W-1:0]  m_loudest_rms,
    output logic              m_last_result
);

    logic [COEF_W-1:0] coef_reg;
    logic [ACT_W-1:0]  act_reg;
    logic [COEF_W-1:0] coef_eff;
    logic [ACT_W-1:0]  act_eff;
    logic              m_valid_reg;
    apm_report_t       out_reg;
    apm_report_t       rep;
    logic              rep_valid;
    logic              rep_take;

    assign coef_eff = (coef_reg > COEF_ONE) ? COEF_ONE : coef_reg;
    assign act_eff  = (act_reg > ACT_MAX) ? ACT_MAX : act_reg;
    assign rep_take = rep_valid && (!m_valid_reg || m_ready);

    apm_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .req_type      (s_req_type),
        .sample_value  (s_sample_value),
        .channel_index (s_channel_index),
        .block_end     (s_block_end),
        .coef          (coef_eff),
        .n_active      (act_eff),
        .rep_valid     (rep_valid),
        .rep_take      (rep_take),
        .rep           (rep)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= COEF_RESET;
            act_reg  <= ACT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_COEF: begin
                    coef_reg <= cfg_data;
                end
                REG_ACTIVE: begin
                    act_reg <= cfg_data[ACT_W-1:0];
                end
                default: begin
                    coef_reg <= coef_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rep_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rep_take) begin
            out_reg <= rep;
        end
    end

    assign m_valid                 = m_valid_reg;
    assign m_report_kind           = out_reg.kind;
    assign m_report_channel        = out_reg.channel;
    assign m_channel_peak          = out_reg.peak;
    assign m_channel_rms           = out_reg.rms;
    assign m_peak_since_read_value = out_reg.psr;
    assign m_clip_seen             = out_reg.clip;
    assign m_loudest_peak          = out_reg.lpeak;
    assign m_loudest_rms           = out_reg.lrms;
    assign m_last_result           = 1'b1;

endmodule

// File: tb/audio_peak_rms_meter_unit_tb.sv
`timescale 1ns / 100ps

module audio_peak_rms_meter_unit_tb;
    import apm_pkg::*;

    localparam int CYCLE_LIMIT    = 600000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int RANDOM_PHASES  = 7;
    localparam int PHASE_ITEMS    = 150;
    localparam logic [MAG_W-1:0] FS    = 24'h800000;
    localparam logic [MAG_W-1:0] FS_M1 = 24'h7FFFFF;

    typedef struct {
        bit               is_cfg;
        logic [IDX_W-1:0] reg_idx;
        logic [COEF_W-1:0] reg_val;
        logic             req;
        logic [SMP_W-1:0] smp;
        logic [CH_W-1:0]  ch;
        logic             blk;
        bit               typed;
        apm_report_t      rep;
    } meter_row_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_wr_en;
    logic [IDX_W-1:0]  cfg_index;
    logic [COEF_W-1:0] cfg_data;
    logic              s_valid;
    logic              s_ready;
    logic              s_req_type;
    logic [SMP_W-1:0]  s_sample_value;
    logic [CH_W-1:0]   s_channel_index;
    logic              s_block_end;
    logic              m_valid;
    logic              m_ready;
    logic              m_report_kind;
    logic [CH_W-1:0]   m_report_channel;
    logic [MAG_W-1:0]  m_channel_peak;
    logic [MAG_W-1:0]  m_channel_rms;
    logic [MAG_W-1:0]  m_peak_since_read_value;
    logic              m_clip_seen;
    logic [MAG_W-1:0]  m_loudest_peak;
    logic [MAG_W-1:0]  m_loudest_rms;
    logic              m_last_result;

    logic [MS_W-1:0]   ms_acc [NCH];
    logic [MAG_W-1:0]  run_peak [NCH];
    logic [MAG_W-1:0]  kept_peak [NCH];
    logic [MAG_W-1:0]  kept_rms [NCH];
    logic [MAG_W-1:0]  held_max;
    logic              clip_sticky;
    logic [COEF_W-1:0] coef_reg;
    logic [ACT_W-1:0]  active_reg;

    apm_report_t reports_due[$];
    meter_row_t  plan[$];
    apm_report_t arrived;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          stall_left = 0;
    bit          idle_on = 1'b1;

    audio_peak_rms_meter_unit u_dut (
        .aclk                    (aclk),
        .aresetn                 (aresetn),
        .cfg_wr_en               (cfg_wr_en),
        .cfg_index               (cfg_index),
        .cfg_data                (cfg_data),
        .s_valid                 (s_valid),
        .s_ready                 (s_ready),
        .s_req_type              (s_req_type),
        .s_sample_value          (s_sample_value),
        .s_channel_index         (s_channel_index),
        .s_block_end             (s_block_end),
        .m_valid                 (m_valid),
        .m_ready                 (m_ready),
        .m_report_kind           (m_report_kind),
        .m_report_channel        (m_report_channel),
        .m_channel_peak          (m_channel_peak),
        .m_channel_rms           (m_channel_rms),
        .m_peak_since_read_value (m_peak_since_read_value),
        .m_clip_seen             (m_clip_seen),
        .m_loudest_peak          (m_loudest_peak),
        .m_loudest_rms           (m_loudest_rms),
        .m_last_result           (m_last_result)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [MAG_W-1:0] floor_sqrt(logic [MS_W-1:0] v);
        logic [MAG_W-1:0] r;
        logic [MAG_W-1:0] t;
        r = '0;
        for (int b = MAG_W - 1; b >= 0; b--) begin
            t = r | (MAG_W'(1) << b);
            if (MS_W'(t) * MS_W'(t) <= v) begin
                r = t;
            end
        end
        return r;
    endfunction

    // Rounds coef * d / 2^24 to nearest, ties away from zero, without overflow.
    function automatic logic [63:0] weighted_step(logic [63:0] c, logic [63:0] d);
        return c * (d >> 24) + ((c * 64'(d[23:0]) + (64'd1 << 23)) >> 24);
    endfunction

    function automatic bit meter_update(input logic req, input logic [SMP_W-1:0] smp,
                                        input logic [CH_W-1:0] ch, input logic blk,
                                        output apm_report_t rep);
        logic [MAG_W-1:0] mag;
        logic [MS_W-1:0]  sq;
        logic [MS_W-1:0]  ms;
        logic [63:0]      c;
        int               n;
        rep = '0;
        if (req == REQ_CONSUME) begin
            rep.kind = REP_CONSUME;
            rep.psr  = held_max;
            held_max = '0;
        end else begin
            mag = smp[SMP_W-1] ? MAG_W'(-smp) : smp;
            if (mag > run_peak[ch]) begin
                run_peak[ch] = mag;
            end
            sq = MS_W'(mag) * MS_W'(mag);
            ms = ms_acc[ch];
            c  = (coef_reg > COEF_ONE) ? 64'(COEF_ONE) : 64'(coef_reg);
            if (sq >= ms) begin
                ms = ms + MS_W'(weighted_step(c, 64'(sq - ms)));
            end else begin
                ms = ms - MS_W'(weighted_step(c, 64'(ms - sq)));
            end
            ms_acc[ch] = ms;
            if (!blk) begin
                return 1'b0;
            end
            kept_peak[ch] = run_peak[ch];
            kept_rms[ch]  = floor_sqrt(ms);
            run_peak[ch]  = '0;
            if (kept_peak[ch] >= FS) begin
                clip_sticky = 1'b1;
            end
            if (kept_peak[ch] > held_max) begin
                held_max = kept_peak[ch];
            end
            rep.kind    = REP_BLOCK;
            rep.channel = ch;
            rep.peak    = kept_peak[ch];
            rep.rms     = kept_rms[ch];
            rep.psr     = held_max;
        end
        rep.clip = clip_sticky;
        n = (active_reg > ACT_MAX) ? NCH : int'(active_reg);
        for (int i = 0; i < n; i++) begin
            if (kept_peak[i] > rep.lpeak) begin
                rep.lpeak = kept_peak[i];
            end
            if (kept_rms[i] > rep.lrms) begin
                rep.lrms = kept_rms[i];
            end
        end
        return 1'b1;
    endfunction

    function automatic void add_cfg(logic [IDX_W-1:0] idx, logic [COEF_W-1:0] val);
        meter_row_t row;
        row = '{default: '0};
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        plan.push_back(row);
    endfunction

    function automatic void add_item(logic req, logic [SMP_W-1:0] smp, logic [CH_W-1:0] ch,
                                     logic blk, bit typed = 1'b0, apm_report_t rep = '0);
        meter_row_t row;
        row = '{default: '0};
        row.req   = req;
        row.smp   = smp;
        row.ch    = ch;
        row.blk   = blk;
        row.typed = typed;
        row.rep   = rep;
        plan.push_back(row);
    endfunction

    task automatic drain(bit settle);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (reports_due.size() != 0) begin
            @(posedge aclk);
        end
        if (settle) begin
            repeat (SETTLE_CYCLES) @(posedge aclk);
        end
    endtask

    task automatic program_reg(logic [IDX_W-1:0] idx, logic [COEF_W-1:0] val);
        drain(1'b1);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_COEF:   coef_reg = val;
            REG_ACTIVE: active_reg = val[ACT_W-1:0];
            default:    ;
        endcase
    endtask

    task automatic send_item(logic req, logic [SMP_W-1:0] smp, logic [CH_W-1:0] ch,
                             logic blk, bit typed, apm_report_t typed_rep);
        int          gap;
        apm_report_t predicted;
        gap = idle_on ? $urandom_range(0, 12) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_req_type      <= req;
        s_sample_value  <= smp;
        s_channel_index <= ch;
        s_block_end     <= blk;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        if (meter_update(req, smp, ch, blk, predicted)) begin
            reports_due.push_back(typed ? typed_rep : predicted);
        end
    endtask

    task automatic check_field(string name, logic [MAG_W-1:0] exp_v, logic [MAG_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // After each transaction the receiver may stall; stalls run down only under m_valid.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left = 0;
        end else if (m_valid && m_ready) begin
            stall_left = idle_on ? $urandom_range(0, 12) : 0;
            m_ready <= (stall_left == 0);
        end else begin
            if (m_valid && stall_left != 0) begin
                stall_left = stall_left - 1;
            end
            m_ready <= (stall_left == 0);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (reports_due.size() == 0) begin
                $error("unexpected report: kind %0d, channel %0d",
                       m_report_kind, m_report_channel);
                mismatch_count++;
            end else begin
                arrived = reports_due.pop_front();
                check_field("report_kind", MAG_W'(arrived.kind), MAG_W'(m_report_kind));
                check_field("report_channel", MAG_W'(arrived.channel),
                            MAG_W'(m_report_channel));
                check_field("channel_peak", arrived.peak, m_channel_peak);
                check_field("channel_rms", arrived.rms, m_channel_rms);
                check_field("peak_since_read_value", arrived.psr, m_peak_since_read_value);
                check_field("clip_seen", MAG_W'(arrived.clip), MAG_W'(m_clip_seen));
                check_field("loudest_peak", arrived.lpeak, m_loudest_peak);
                check_field("loudest_rms", arrived.lrms, m_loudest_rms);
                check_field("last_result", MAG_W'(1), MAG_W'(m_last_result));
            end
        end
    end

    initial begin
        logic [SMP_W-1:0]  smp;
        logic [COEF_W-1:0] coef_pick;
        logic              req;
        int                pick;

        aresetn         <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_index       <= REG_COEF;
        cfg_data        <= '0;
        s_valid         <= 1'b0;
        s_req_type      <= REQ_SAMPLE;
        s_sample_value  <= '0;
        s_channel_index <= '0;
        s_block_end     <= 1'b0;

        for (int i = 0; i < NCH; i++) begin
            ms_acc[i]    = '0;
            run_peak[i]  = '0;
            kept_peak[i] = '0;
            kept_rms[i]  = '0;
        end
        held_max    = '0;
        clip_sticky = 1'b0;
        coef_reg    = COEF_RESET;
        active_reg  = ACT_RESET;

        // With a coefficient of one the mean square equals x*x, so rms equals the magnitude.
        add_item(REQ_CONSUME, '0, 3'd0, 1'b0, 1'b1, '{REP_CONSUME, 3'd0, 24'd0, 24'd0, 24'd0,
                 1'b0, 24'd0, 24'd0});
        add_item(REQ_SAMPLE, '0, 3'd0, 1'b1, 1'b1, '{REP_BLOCK, 3'd0, 24'd0, 24'd0, 24'd0,
                 1'b0, 24'd0, 24'd0});
        add_cfg(REG_COEF, COEF_ONE);
        add_item(REQ_SAMPLE, 24'h800000, 3'd1, 1'b1, 1'b1, '{REP_BLOCK, 3'd1, FS, FS, FS,
                 1'b1, FS, FS});
        add_item(REQ_SAMPLE, 24'h7FFFFF, 3'd2, 1'b1, 1'b1, '{REP_BLOCK, 3'd2, FS_M1, FS_M1, FS,
                 1'b1, FS, FS});
        add_item(REQ_CONSUME, '0, 3'd0, 1'b0, 1'b1, '{REP_CONSUME, 3'd0, 24'd0, 24'd0, FS,
                 1'b1, FS, FS});
        add_item(REQ_CONSUME, 24'hFFFFFF, 3'd7, 1'b1, 1'b1, '{REP_CONSUME, 3'd0, 24'd0, 24'd0,
                 24'd0, 1'b1, FS, FS});
        add_cfg(REG_ACTIVE, 25'd0);
        add_item(REQ_CONSUME, '0, 3'd0, 1'b0, 1'b1, '{REP_CONSUME, 3'd0, 24'd0, 24'd0, 24'd0,
                 1'b1, 24'd0, 24'd0});
        add_cfg(REG_ACTIVE, 25'd15);
        add_item(REQ_CONSUME, '0, 3'd0, 1'b0, 1'b1, '{REP_CONSUME, 3'd0, 24'd0, 24'd0, 24'd0,
                 1'b1, FS, FS});
        add_cfg(REG_COEF, 25'd0);
        add_item(REQ_SAMPLE, 24'd100, 3'd1, 1'b1);
        add_cfg(REG_COEF, 25'h1FFFFFF);
        add_item(REQ_SAMPLE, -24'sd5, 3'd3, 1'b0);
        add_item(REQ_SAMPLE, 24'd3, 3'd3, 1'b1);
        add_cfg(REG_COEF, 25'd1);
        add_item(REQ_SAMPLE, 24'h7FFFFF, 3'd7, 1'b0);
        add_item(REQ_SAMPLE, 24'hFFFFFF, 3'd7, 1'b1);
        add_cfg(REG_ACTIVE, 25'd8);
        add_item(REQ_SAMPLE, 24'h000001, 3'd7, 1'b0);
        add_item(REQ_SAMPLE, 24'hAAAAAA, 3'd5, 1'b1);
        add_item(REQ_SAMPLE, 24'h555555, 3'd6, 1'b1);
        add_item(REQ_CONSUME, 24'h123456, 3'd4, 1'b1);
        add_cfg(REG_COEF, COEF_RESET);
        add_cfg(REG_ACTIVE, 25'd1);
        add_item(REQ_SAMPLE, 24'h800001, 3'd0, 1'b1);
        add_item(REQ_SAMPLE, 24'h400000, 3'd1, 1'b1);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                program_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                send_item(plan[i].req, plan[i].smp, plan[i].ch, plan[i].blk,
                          plan[i].typed, plan[i].rep);
            end
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 5))
                0:       coef_pick = '0;
                1:       coef_pick = 25'd1;
                2:       coef_pick = COEF_ONE;
                3:       coef_pick = 25'h1FFFFFF;
                4:       coef_pick = 25'($urandom_range(1, 4096));
                default: coef_pick = 25'($urandom());
            endcase
            program_reg(REG_COEF, coef_pick);
            program_reg(REG_ACTIVE, 25'($urandom_range(0, 15)));
            idle_on = (phase % 3 != 0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 49) == 0) begin
                    drain(1'b0);
                end
                req  = ($urandom_range(0, 9) == 0) ? REQ_CONSUME : REQ_SAMPLE;
                pick = $urandom_range(0, 9);
                case (pick)
                    0:       smp = 24'h800000;
                    1:       smp = 24'h7FFFFF;
                    2:       smp = 24'hFFFFFF;
                    3:       smp = 24'($urandom_range(0, 255));
                    default: smp = 24'($urandom());
                endcase
                send_item(req, smp, 3'($urandom_range(0, 7)), ($urandom_range(0, 3) == 0),
                          1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        while (reports_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/apm_pkg.sv
hdl/apm_alu.sv
hdl/apm_core.sv
hdl/audio_peak_rms_meter_unit.sv
tb/audio_peak_rms_meter_unit_tb.sv
